// ===== rtl/core/ter_pkg.sv =====
// Shared constants and controller/datapath command types for the triangle rasterizer.
`timescale 1ns / 1ps

package ter_pkg;

  // Field widths
  localparam int VTX_W   = 16;
  localparam int COLOR_W = 8;
  localparam int OUT_W   = 12;
  localparam int MASK_W  = 32;

  // Fixed-point format and box limits
  localparam int FRAC_BITS     = 4;
  localparam int MAX_BOX_WIDTH = 32;
  localparam int MAX_BOX_ROWS  = 32;
  localparam int COL_LIMIT     = (MAX_BOX_WIDTH < MASK_W) ? MAX_BOX_WIDTH : MASK_W;
  localparam int ROW_LIMIT     = (MAX_BOX_ROWS < 32) ? MAX_BOX_ROWS : 32;

  // Derived internal widths
  localparam int PIX_W      = VTX_W - FRAC_BITS + 1;  // integer pixel coordinate
  localparam int DIF_W      = VTX_W + 3;              // doubled-coordinate differences
  localparam int PRD_W      = 2 * DIF_W;              // edge product
  localparam int EDGE_W     = PRD_W + 2;              // edge value with lane and row steps
  localparam int COL_CNT_W  = $clog2(COL_LIMIT + 1);
  localparam int ROW_CNT_W  = $clog2(ROW_LIMIT + 1);
  localparam int COL_IDX_W  = $clog2(COL_LIMIT);
  localparam int NUM_EDGES  = 3;

  // Controller states
  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_BBOX   = 7'b0000010,
    ST_DELTA  = 7'b0000100,
    ST_MULT   = 7'b0001000,
    ST_BASE   = 7'b0010000,
    ST_SPREAD = 7'b0100000,
    ST_ROW    = 7'b1000000
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;    // capture the triangle
    logic bbox;    // form the bounding box
    logic delta;   // form edge deltas and box size
    logic mult;    // edge products and steps
    logic base;    // edge values at the box corner
    logic spread;  // edge values across the row lanes
    logic row;     // emit one row and step down
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic last;    // current row is the final one
  } sts_t;

endpackage

// ===== rtl/core/ter_ctrl.sv =====
// Sequencing state machine for the triangle rasterizer.
`timescale 1ns / 1ps

module ter_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  ter_pkg::sts_t sts,
  output ter_pkg::cmd_t cmd,
  output logic          busy
);

  ter_pkg::state_t state, state_next;

  // Step through setup, then one row per cycle
  always_comb begin
    state_next = state;
    unique case (state)
      ter_pkg::ST_IDLE:   if (start) state_next = ter_pkg::ST_BBOX;
      ter_pkg::ST_BBOX:   state_next = ter_pkg::ST_DELTA;
      ter_pkg::ST_DELTA:  state_next = ter_pkg::ST_MULT;
      ter_pkg::ST_MULT:   state_next = ter_pkg::ST_BASE;
      ter_pkg::ST_BASE:   state_next = ter_pkg::ST_SPREAD;
      ter_pkg::ST_SPREAD: state_next = ter_pkg::ST_ROW;
      ter_pkg::ST_ROW:    if (sts.last) state_next = ter_pkg::ST_IDLE;
      default:            state_next = ter_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ter_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Decode commands
  always_comb begin
    cmd.load   = (state == ter_pkg::ST_IDLE) && start;
    cmd.bbox   = (state == ter_pkg::ST_BBOX);
    cmd.delta  = (state == ter_pkg::ST_DELTA);
    cmd.mult   = (state == ter_pkg::ST_MULT);
    cmd.base   = (state == ter_pkg::ST_BASE);
    cmd.spread = (state == ter_pkg::ST_SPREAD);
    cmd.row    = (state == ter_pkg::ST_ROW);
  end

  assign busy = (state != ter_pkg::ST_IDLE);

endmodule

// ===== rtl/core/ter_datapath.sv =====
// Bounding box, edge-function lanes and row result registers of the triangle rasterizer.
`timescale 1ns / 1ps

module ter_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  ter_pkg::cmd_t                        cmd,
  output ter_pkg::sts_t                        sts,
  input  logic signed [ter_pkg::VTX_W-1:0]     vertex_a_x,
  input  logic signed [ter_pkg::VTX_W-1:0]     vertex_a_y,
  input  logic signed [ter_pkg::VTX_W-1:0]     vertex_b_x,
  input  logic signed [ter_pkg::VTX_W-1:0]     vertex_b_y,
  input  logic signed [ter_pkg::VTX_W-1:0]     vertex_c_x,
  input  logic signed [ter_pkg::VTX_W-1:0]     vertex_c_y,
  input  logic        [ter_pkg::COLOR_W-1:0]   fill_red,
  input  logic        [ter_pkg::COLOR_W-1:0]   fill_green,
  input  logic        [ter_pkg::COLOR_W-1:0]   fill_blue,
  input  logic        [ter_pkg::COLOR_W-1:0]   fill_alpha,
  output logic                                 result_valid,
  output logic signed [ter_pkg::OUT_W-1:0]     row_y,
  output logic signed [ter_pkg::OUT_W-1:0]     span_start_x,
  output logic        [ter_pkg::MASK_W-1:0]    coverage_mask,
  output logic        [ter_pkg::COLOR_W-1:0]   out_red,
  output logic        [ter_pkg::COLOR_W-1:0]   out_green,
  output logic        [ter_pkg::COLOR_W-1:0]   out_blue,
  output logic        [ter_pkg::COLOR_W-1:0]   out_alpha,
  output logic                                 box_clipped,
  output logic                                 last_row
);

  localparam int VTX_W     = ter_pkg::VTX_W;
  localparam int PIX_W     = ter_pkg::PIX_W;
  localparam int DIF_W     = ter_pkg::DIF_W;
  localparam int PRD_W     = ter_pkg::PRD_W;
  localparam int EDGE_W    = ter_pkg::EDGE_W;
  localparam int FRAC      = ter_pkg::FRAC_BITS;
  localparam int LANES     = ter_pkg::COL_LIMIT;
  localparam int NE        = ter_pkg::NUM_EDGES;
  localparam int COL_CNT_W = ter_pkg::COL_CNT_W;
  localparam int ROW_CNT_W = ter_pkg::ROW_CNT_W;
  localparam int COL_IDX_W = ter_pkg::COL_IDX_W;

  localparam logic signed [VTX_W:0]   CEIL_ADD = (VTX_W + 1)'((1 << FRAC) - 1);
  localparam logic signed [DIF_W-1:0] HALF     = DIF_W'(1 << FRAC);

  function automatic logic signed [VTX_W-1:0] min3(input logic signed [VTX_W-1:0] a,
                                                    input logic signed [VTX_W-1:0] b,
                                                    input logic signed [VTX_W-1:0] c);
    logic signed [VTX_W-1:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic logic signed [VTX_W-1:0] max3(input logic signed [VTX_W-1:0] a,
                                                    input logic signed [VTX_W-1:0] b,
                                                    input logic signed [VTX_W-1:0] c);
    logic signed [VTX_W-1:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  // Arithmetic shift floors toward minus infinity
  function automatic logic signed [PIX_W-1:0] floor_px(input logic signed [VTX_W-1:0] v);
    logic signed [VTX_W:0] w;
    w = (VTX_W + 1)'(v);
    return PIX_W'(w >>> FRAC);
  endfunction

  function automatic logic signed [PIX_W-1:0] ceil_px(input logic signed [VTX_W-1:0] v);
    logic signed [VTX_W:0] w;
    w = (VTX_W + 1)'(v) + CEIL_ADD;
    return PIX_W'(w >>> FRAC);
  endfunction

  // Lane index times column step, as shifted adds
  function automatic logic signed [EDGE_W-1:0] lane_offset(
      input logic signed [EDGE_W-1:0] step, input logic [COL_IDX_W-1:0] idx);
    logic signed [EDGE_W-1:0] acc;
    acc = '0;
    for (int b = 0; b < COL_IDX_W; b++) begin
      if (idx[b]) acc = acc + (step <<< b);
    end
    return acc;
  endfunction

  // Captured triangle
  logic signed [VTX_W-1:0] vx [NE];
  logic signed [VTX_W-1:0] vy [NE];
  logic [ter_pkg::COLOR_W-1:0] red, green, blue, alpha;

  // Bounding box
  logic signed [PIX_W-1:0] min_x, max_x, min_y, max_y;

  // Edge setup
  logic signed [DIF_W-1:0]  rx [NE];
  logic signed [DIF_W-1:0]  ry [NE];
  logic signed [DIF_W-1:0]  ddx [NE];
  logic signed [DIF_W-1:0]  ddy [NE];
  logic signed [PRD_W-1:0]  prod_x [NE];
  logic signed [PRD_W-1:0]  prod_y [NE];
  logic signed [EDGE_W-1:0] col_step [NE];
  logic signed [EDGE_W-1:0] row_step [NE];
  logic signed [EDGE_W-1:0] edge0 [NE];
  logic signed [EDGE_W-1:0] lane [NE][LANES];

  // Row walk
  logic [COL_CNT_W-1:0]    cols;
  logic [ROW_CNT_W-1:0]    rows;
  logic [ROW_CNT_W-1:0]    row_idx;
  logic signed [PIX_W-1:0] row_cur;
  logic                    clipped;

  // Delta-stage combinational terms
  logic signed [DIF_W-1:0] px0, py0;
  logic signed [DIF_W-1:0] vx2 [NE];
  logic signed [DIF_W-1:0] vy2 [NE];
  logic signed [PIX_W:0]   span_x, span_y;
  logic                    clip_x, clip_y;

  logic [ter_pkg::MASK_W-1:0] mask_next;

  // Capture the triangle on transfer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      vx[0] <= vertex_a_x;
      vy[0] <= vertex_a_y;
      vx[1] <= vertex_b_x;
      vy[1] <= vertex_b_y;
      vx[2] <= vertex_c_x;
      vy[2] <= vertex_c_y;
      red   <= fill_red;
      green <= fill_green;
      blue  <= fill_blue;
      alpha <= fill_alpha;
    end
  end

  // Form the integer bounding box
  always_ff @(posedge clk) begin
    if (cmd.bbox) begin
      min_x <= floor_px(min3(vx[0], vx[1], vx[2]));
      max_x <= ceil_px(max3(vx[0], vx[1], vx[2]));
      min_y <= floor_px(min3(vy[0], vy[1], vy[2]));
      max_y <= ceil_px(max3(vy[0], vy[1], vy[2]));
    end
  end

  // Corner pixel centre, doubled vertices and box size
  always_comb begin
    px0 = (DIF_W'(min_x) <<< (FRAC + 1)) + HALF;
    py0 = (DIF_W'(min_y) <<< (FRAC + 1)) + HALF;
    for (int e = 0; e < NE; e++) begin
      vx2[e] = DIF_W'(vx[e]) <<< 1;
      vy2[e] = DIF_W'(vy[e]) <<< 1;
    end
    span_x = (PIX_W + 1)'(max_x) - (PIX_W + 1)'(min_x);
    span_y = (PIX_W + 1)'(max_y) - (PIX_W + 1)'(min_y);
    clip_x = (span_x >= ter_pkg::COL_LIMIT);
    clip_y = (span_y >= ter_pkg::ROW_LIMIT);
  end

  // Edge deltas; edge e runs from vertex e to the next vertex
  always_ff @(posedge clk) begin
    if (cmd.delta) begin
      for (int e = 0; e < NE; e++) begin
        rx[e]  <= px0 - vx2[e];
        ry[e]  <= py0 - vy2[e];
        ddx[e] <= vx2[(e == NE - 1) ? 0 : e + 1] - vx2[e];
        ddy[e] <= vy2[(e == NE - 1) ? 0 : e + 1] - vy2[e];
      end
      cols    <= clip_x ? COL_CNT_W'(ter_pkg::COL_LIMIT)
                        : COL_CNT_W'(span_x) + COL_CNT_W'(1);
      rows    <= clip_y ? ROW_CNT_W'(ter_pkg::ROW_LIMIT)
                        : ROW_CNT_W'(span_y) + ROW_CNT_W'(1);
      clipped <= clip_x || clip_y;
    end
  end

  // Edge products and per-pixel steps
  always_ff @(posedge clk) begin
    if (cmd.mult) begin
      for (int e = 0; e < NE; e++) begin
        prod_x[e]   <= rx[e] * ddy[e];
        prod_y[e]   <= ry[e] * ddx[e];
        col_step[e] <= EDGE_W'(ddy[e]) <<< (FRAC + 1);
        row_step[e] <= -(EDGE_W'(ddx[e]) <<< (FRAC + 1));
      end
    end
  end

  // Edge values at the box corner
  always_ff @(posedge clk) begin
    if (cmd.base) begin
      for (int e = 0; e < NE; e++) begin
        edge0[e] <= EDGE_W'(prod_x[e]) - EDGE_W'(prod_y[e]);
      end
    end
  end

  // Spread edge values across the lanes, then advance one row at a time
  always_ff @(posedge clk) begin
    for (int e = 0; e < NE; e++) begin
      for (int i = 0; i < LANES; i++) begin
        if (cmd.spread) begin
          lane[e][i] <= edge0[e] + lane_offset(col_step[e], COL_IDX_W'(i));
        end else if (cmd.row) begin
          lane[e][i] <= lane[e][i] + row_step[e];
        end
      end
    end
  end

  // Coverage: all edges non-negative or all non-positive, inside the box width
  always_comb begin
    logic all_pos, all_neg;
    mask_next = '0;
    for (int i = 0; i < LANES; i++) begin
      all_pos = 1'b1;
      all_neg = 1'b1;
      for (int e = 0; e < NE; e++) begin
        all_pos = all_pos && !lane[e][i][EDGE_W-1];
        all_neg = all_neg && (lane[e][i][EDGE_W-1] || (lane[e][i] == '0));
      end
      mask_next[i] = (all_pos || all_neg) && (COL_CNT_W'(i) < cols);
    end
  end

  assign sts.last = ((row_idx + ROW_CNT_W'(1)) == rows);

  // Row walk counters
  always_ff @(posedge clk) begin
    if (cmd.delta) begin
      row_idx <= '0;
      row_cur <= min_y;
    end else if (cmd.row) begin
      row_idx <= row_idx + ROW_CNT_W'(1);
      row_cur <= row_cur + PIX_W'(1);
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (cmd.row) begin
      row_y         <= row_cur[ter_pkg::OUT_W-1:0];
      span_start_x  <= min_x[ter_pkg::OUT_W-1:0];
      coverage_mask <= mask_next;
      out_red       <= red;
      out_green     <= green;
      out_blue      <= blue;
      out_alpha     <= alpha;
      box_clipped   <= clipped;
      last_row      <= sts.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.row;
    end
  end

endmodule

// ===== rtl/core/triangle_edge_rasterizer_top.sv =====
// Triangle edge-function rasterizer: one result per bounding-box row.
// Sequence: the start transfer captures the triangle, then five setup steps (box, deltas,
//   products, corner values, lane spread), then one row per cycle; busy stays high until the last
//   row is formed, and start is taken again the cycle after. Results cannot be stalled; each is
//   shown for one cycle with result_valid.
// Reset (rst, synchronous) returns the sequencer to idle and clears result_valid.
`timescale 1ns / 1ps

module triangle_edge_rasterizer_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [ter_pkg::VTX_W-1:0]     vertex_a_x,
  input  logic signed [ter_pkg::VTX_W-1:0]     vertex_a_y,
  input  logic signed [ter_pkg::VTX_W-1:0]     vertex_b_x,
  input  logic signed [ter_pkg::VTX_W-1:0]     vertex_b_y,
  input  logic signed [ter_pkg::VTX_W-1:0]     vertex_c_x,
  input  logic signed [ter_pkg::VTX_W-1:0]     vertex_c_y,
  input  logic        [ter_pkg::COLOR_W-1:0]   fill_red,
  input  logic        [ter_pkg::COLOR_W-1:0]   fill_green,
  input  logic        [ter_pkg::COLOR_W-1:0]   fill_blue,
  input  logic        [ter_pkg::COLOR_W-1:0]   fill_alpha,
  output logic                                 result_valid,
  output logic signed [ter_pkg::OUT_W-1:0]     row_y,
  output logic signed [ter_pkg::OUT_W-1:0]     span_start_x,
  output logic        [ter_pkg::MASK_W-1:0]    coverage_mask,
  output logic        [ter_pkg::COLOR_W-1:0]   out_red,
  output logic        [ter_pkg::COLOR_W-1:0]   out_green,
  output logic        [ter_pkg::COLOR_W-1:0]   out_blue,
  output logic        [ter_pkg::COLOR_W-1:0]   out_alpha,
  output logic                                 box_clipped,
  output logic                                 last_row
);

  ter_pkg::cmd_t cmd;
  ter_pkg::sts_t sts;

  ter_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  ter_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .vertex_a_x    (vertex_a_x),
    .vertex_a_y    (vertex_a_y),
    .vertex_b_x    (vertex_b_x),
    .vertex_b_y    (vertex_b_y),
    .vertex_c_x    (vertex_c_x),
    .vertex_c_y    (vertex_c_y),
    .fill_red      (fill_red),
    .fill_green    (fill_green),
    .fill_blue     (fill_blue),
    .fill_alpha    (fill_alpha),
    .result_valid  (result_valid),
    .row_y         (row_y),
    .span_start_x  (span_start_x),
    .coverage_mask (coverage_mask),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_alpha     (out_alpha),
    .box_clipped   (box_clipped),
    .last_row      (last_row)
  );

`ifndef SYNTH
  // A row result only follows a cycle of work
  a_result_needs_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("row result without a triangle in progress");

  // Rows of one triangle come out back to back
  a_rows_contiguous: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !last_row) |=> result_valid)
    else $error("gap between rows of one triangle");

  // The last row closes the triangle; setup keeps the next one away
  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    (result_valid && last_row) |=> !result_valid)
    else $error("row result right after the last row");

  // A start transfer always begins work
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("start transfer did not raise busy");
`endif

endmodule

// ===== test/triangle_edge_rasterizer_top_tb.sv =====
// Self-checking testbench for the triangle edge-function rasterizer top level.
`timescale 1ns / 1ps

module triangle_edge_rasterizer_top_tb;

  localparam int FB = ter_pkg::FRAC_BITS;

  typedef struct {
    logic signed [ter_pkg::VTX_W-1:0]  ax, ay, bx, by, cx, cy;
    logic        [ter_pkg::COLOR_W-1:0] r, g, b, a;
  } triangle_t;

  typedef struct {
    logic signed [ter_pkg::OUT_W-1:0]   y;
    logic signed [ter_pkg::OUT_W-1:0]   x0;
    logic        [ter_pkg::MASK_W-1:0]  mask;
    logic        [ter_pkg::COLOR_W-1:0] r, g, b, a;
    logic                               clip;
    logic                               last;
  } span_row_t;

  // Directed row: when known_rows is set the expected spans are typed in,
  // every row carrying the same mask
  typedef struct {
    triangle_t   shape;
    bit          known_rows;
    int          n_rows;
    int          y0;
    int          x0;
    logic [31:0] mask;
    bit          clip;
  } directed_t;

  logic clk;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [ter_pkg::VTX_W-1:0]   vertex_a_x = '0, vertex_a_y = '0;
  logic signed [ter_pkg::VTX_W-1:0]   vertex_b_x = '0, vertex_b_y = '0;
  logic signed [ter_pkg::VTX_W-1:0]   vertex_c_x = '0, vertex_c_y = '0;
  logic        [ter_pkg::COLOR_W-1:0] fill_red = '0, fill_green = '0;
  logic        [ter_pkg::COLOR_W-1:0] fill_blue = '0, fill_alpha = '0;
  logic                               result_valid;
  logic signed [ter_pkg::OUT_W-1:0]   row_y;
  logic signed [ter_pkg::OUT_W-1:0]   span_start_x;
  logic        [ter_pkg::MASK_W-1:0]  coverage_mask;
  logic        [ter_pkg::COLOR_W-1:0] out_red, out_green, out_blue, out_alpha;
  logic                               box_clipped;
  logic                               last_row;

  span_row_t pending_rows[$];
  span_row_t want_row;
  int        errors = 0;
  int        n_triangles = 0;
  int        n_rows_seen = 0;
  int        n_clipped = 0;

  triangle_edge_rasterizer_top u_top (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .vertex_a_x    (vertex_a_x),
    .vertex_a_y    (vertex_a_y),
    .vertex_b_x    (vertex_b_x),
    .vertex_b_y    (vertex_b_y),
    .vertex_c_x    (vertex_c_x),
    .vertex_c_y    (vertex_c_y),
    .fill_red      (fill_red),
    .fill_green    (fill_green),
    .fill_blue     (fill_blue),
    .fill_alpha    (fill_alpha),
    .result_valid  (result_valid),
    .row_y         (row_y),
    .span_start_x  (span_start_x),
    .coverage_mask (coverage_mask),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_alpha     (out_alpha),
    .box_clipped   (box_clipped),
    .last_row      (last_row)
  );

  // Clock: 8 ns period
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("Timeout with %0d span rows still expected", pending_rows.size());
    $display("== FAIL ==");
    $finish;
  end

  function automatic triangle_t mk_tri(int ax, int ay, int bx, int by, int cx, int cy,
                                       int r, int g, int b, int a);
    triangle_t t;
    t.ax = 16'(ax); t.ay = 16'(ay);
    t.bx = 16'(bx); t.by = 16'(by);
    t.cx = 16'(cx); t.cy = 16'(cy);
    t.r  = 8'(r);   t.g  = 8'(g);
    t.b  = 8'(b);   t.a  = 8'(a);
    return t;
  endfunction

  function automatic longint min3(longint p, longint q, longint s);
    longint m;
    m = (p < q) ? p : q;
    return (m < s) ? m : s;
  endfunction

  function automatic longint max3(longint p, longint q, longint s);
    longint m;
    m = (p > q) ? p : q;
    return (m > s) ? m : s;
  endfunction

  // Edge function on doubled coordinates; only its sign is used
  function automatic longint edge_fn(longint x0, longint y0, longint x1, longint y1,
                                     longint px, longint py);
    return (px - x0) * (y1 - y0) - (py - y0) * (x1 - x0);
  endfunction

  // Rasterize one triangle into per-row coverage spans and queue them
  function automatic void rasterize(triangle_t t);
    longint    ax, ay, bx, by, cx, cy;
    longint    min_x, max_x, min_y, max_y, cols, rows, px, py, e0, e1, e2;
    bit        clip;
    span_row_t rw;
    ax = longint'(t.ax); ay = longint'(t.ay);
    bx = longint'(t.bx); by = longint'(t.by);
    cx = longint'(t.cx); cy = longint'(t.cy);
    // floor of the minima, ceiling of the maxima
    min_x = min3(ax, bx, cx) >>> FB;
    min_y = min3(ay, by, cy) >>> FB;
    max_x = -((-max3(ax, bx, cx)) >>> FB);
    max_y = -((-max3(ay, by, cy)) >>> FB);
    cols = max_x - min_x + 1;
    rows = max_y - min_y + 1;
    clip = 1'b0;
    if (cols > ter_pkg::COL_LIMIT) begin
      cols = ter_pkg::COL_LIMIT;
      clip = 1'b1;
    end
    if (rows > ter_pkg::ROW_LIMIT) begin
      rows = ter_pkg::ROW_LIMIT;
      clip = 1'b1;
    end
    for (longint r = 0; r < rows; r++) begin
      py = (min_y + r) * (64'sd1 << (FB + 1)) + (64'sd1 << FB);
      rw.mask = '0;
      for (longint i = 0; i < cols; i++) begin
        px = (min_x + i) * (64'sd1 << (FB + 1)) + (64'sd1 << FB);
        e0 = edge_fn(2 * ax, 2 * ay, 2 * bx, 2 * by, px, py);
        e1 = edge_fn(2 * bx, 2 * by, 2 * cx, 2 * cy, px, py);
        e2 = edge_fn(2 * cx, 2 * cy, 2 * ax, 2 * ay, px, py);
        if ((e0 >= 0 && e1 >= 0 && e2 >= 0) || (e0 <= 0 && e1 <= 0 && e2 <= 0))
          rw.mask[i] = 1'b1;
      end
      rw.y    = 12'(min_y + r);
      rw.x0   = 12'(min_x);
      rw.r    = t.r;
      rw.g    = t.g;
      rw.b    = t.b;
      rw.a    = t.a;
      rw.clip = clip;
      rw.last = (r == rows - 1);
      pending_rows.push_back(rw);
    end
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // Offer one triangle after an idle gap and hold until the start transfer
  task automatic send_tri(triangle_t t, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    vertex_a_x <= t.ax;
    vertex_a_y <= t.ay;
    vertex_b_x <= t.bx;
    vertex_b_y <= t.by;
    vertex_c_x <= t.cx;
    vertex_c_y <= t.cy;
    fill_red   <= t.r;
    fill_green <= t.g;
    fill_blue  <= t.b;
    fill_alpha <= t.a;
    do @(posedge clk); while (busy !== 1'b0);
    n_triangles++;
  endtask

  // Compare each row strobe against the oldest expected span
  always @(posedge clk) begin
    if (!rst && result_valid === 1'b1) begin
      n_rows_seen++;
      if (box_clipped === 1'b1 && last_row === 1'b1)
        n_clipped++;
      if (pending_rows.size() == 0) begin
        errors++;
        $display("%0t ns: row result with none expected, expected none, actual row_y %h",
                 $time, row_y);
      end else begin
        want_row = pending_rows.pop_front();
        check_field("row_y", want_row.y, row_y);
        check_field("span_start_x", want_row.x0, span_start_x);
        check_field("coverage_mask", want_row.mask, coverage_mask);
        check_field("out_red", want_row.r, out_red);
        check_field("out_green", want_row.g, out_green);
        check_field("out_blue", want_row.b, out_blue);
        check_field("out_alpha", want_row.a, out_alpha);
        check_field("box_clipped", want_row.clip, box_clipped);
        check_field("last_row", want_row.last, last_row);
      end
    end
  end

  // Stimulus
  initial begin
    directed_t dir_tbl[$];
    directed_t d;
    triangle_t tr;
    span_row_t w;
    int        gap, kind, n_directed;
    int        px0, py0, sp, dx, dy;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Coincident vertices fill their whole box: typed in
    dir_tbl.push_back('{mk_tri(0, 0, 0, 0, 0, 0, 255, 0, 255, 0),
                        1, 1, 0, 0, 32'h1, 0});
    dir_tbl.push_back('{mk_tri(-32768, -32768, -32768, -32768, -32768, -32768,
                               0, 255, 0, 255),
                        1, 1, -2048, -2048, 32'h1, 0});
    // Top of the range: second row wraps in twelve bits
    dir_tbl.push_back('{mk_tri(32767, 32767, 32767, 32767, 32767, 32767,
                               255, 255, 255, 255),
                        1, 2, 2047, 2047, 32'h3, 0});
    dir_tbl.push_back('{mk_tri(17, 33, 17, 33, 17, 33, 1, 2, 4, 8),
                        1, 2, 2, 1, 32'h3, 0});
    // Huge right triangle: clipped corner is fully inside
    dir_tbl.push_back('{mk_tri(-32768, -32768, 32752, -32768, -32768, 32752,
                               0, 0, 0, 0),
                        1, 32, -2048, -2048, 32'hFFFF_FFFF, 1});
    // Predicted rows: clipping, box sizes at the limit, winding, fractions
    dir_tbl.push_back('{mk_tri(-32768, -32768, 32767, 32767, -32768, 32767,
                               128, 64, 32, 16), 0, 0, 0, 0, 0, 0});
    dir_tbl.push_back('{mk_tri(0, 0, 640, 0, 320, 48, 10, 20, 30, 40), 0, 0, 0, 0, 0, 0});
    dir_tbl.push_back('{mk_tri(0, 0, 48, 640, 0, 320, 50, 60, 70, 80), 0, 0, 0, 0, 0, 0});
    dir_tbl.push_back('{mk_tri(0, 0, 496, 0, 0, 80, 1, 1, 1, 1), 0, 0, 0, 0, 0, 0});
    dir_tbl.push_back('{mk_tri(0, 0, 512, 0, 0, 80, 2, 2, 2, 2), 0, 0, 0, 0, 0, 0});
    dir_tbl.push_back('{mk_tri(0, 0, 80, 0, 0, 496, 3, 3, 3, 3), 0, 0, 0, 0, 0, 0});
    dir_tbl.push_back('{mk_tri(0, 0, 80, 0, 0, 512, 4, 4, 4, 4), 0, 0, 0, 0, 0, 0});
    dir_tbl.push_back('{mk_tri(16, 16, 160, 32, 64, 144, 200, 100, 50, 25),
                        0, 0, 0, 0, 0, 0});
    dir_tbl.push_back('{mk_tri(64, 144, 160, 32, 16, 16, 200, 100, 50, 25),
                        0, 0, 0, 0, 0, 0});
    dir_tbl.push_back('{mk_tri(3, 5, 77, -20, -40, 60, 9, 8, 7, 6), 0, 0, 0, 0, 0, 0});
    // Collinear and two coincident vertices
    dir_tbl.push_back('{mk_tri(0, 0, 48, 48, 96, 96, 11, 22, 33, 44), 0, 0, 0, 0, 0, 0});
    dir_tbl.push_back('{mk_tri(16, 16, 16, 16, 100, 40, 55, 66, 77, 88), 0, 0, 0, 0, 0, 0});
    // Vertices on pixel centres put edges exactly through samples
    dir_tbl.push_back('{mk_tri(8, 8, 72, 8, 8, 72, 5, 4, 3, 2), 0, 0, 0, 0, 0, 0});
    // Near both ends of the coordinate range
    dir_tbl.push_back('{mk_tri(32700, 100, 32767, 200, 32600, 300, 170, 85, 170, 85),
                        0, 0, 0, 0, 0, 0});
    dir_tbl.push_back('{mk_tri(-32768, 0, -32700, 50, -32750, -60, 85, 170, 85, 170),
                        0, 0, 0, 0, 0, 0});

    // Walk the directed table
    foreach (dir_tbl[k]) begin
      d = dir_tbl[k];
      if (d.known_rows) begin
        for (int r = 0; r < d.n_rows; r++) begin
          w.y    = 12'(d.y0 + r);
          w.x0   = 12'(d.x0);
          w.mask = d.mask;
          w.r    = d.shape.r;
          w.g    = d.shape.g;
          w.b    = d.shape.b;
          w.a    = d.shape.a;
          w.clip = d.clip;
          w.last = (r == d.n_rows - 1);
          pending_rows.push_back(w);
        end
      end else begin
        rasterize(d.shape);
      end
      send_tri(d.shape, (k % 4 == 0) ? 0 : $urandom_range(0, 12));
    end
    n_directed = dir_tbl.size();

    // Random triangles: mostly small boxes anywhere, some degenerate,
    // some near the clip limit, some with fully random vertices
    for (int k = 0; k < 150; k++) begin
      kind = $urandom_range(0, 19);
      px0  = int'($urandom_range(0, 64835)) - 32768;
      py0  = int'($urandom_range(0, 64835)) - 32768;
      if (kind <= 12) begin
        sp = $urandom_range(0, 16 * 14);
        tr = mk_tri(px0 + $urandom_range(0, sp), py0 + $urandom_range(0, sp),
                    px0 + $urandom_range(0, sp), py0 + $urandom_range(0, sp),
                    px0 + $urandom_range(0, sp), py0 + $urandom_range(0, sp),
                    $urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom_range(0, 255), $urandom_range(0, 255));
      end else if (kind <= 14) begin
        dx = $urandom_range(0, 100);
        dy = $urandom_range(0, 100);
        if (kind == 13)
          tr = mk_tri(px0, py0, px0, py0, px0, py0,
                      $urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom_range(0, 255), $urandom_range(0, 255));
        else
          tr = mk_tri(px0, py0, px0 + dx, py0 + dy, px0 + 2 * dx, py0 + 2 * dy,
                      $urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom_range(0, 255), $urandom_range(0, 255));
      end else if (kind <= 16) begin
        sp = $urandom_range(16 * 24, 16 * 40);
        tr = mk_tri(px0 + $urandom_range(0, sp), py0 + $urandom_range(0, sp),
                    px0 + $urandom_range(0, sp), py0 + $urandom_range(0, sp),
                    px0 + $urandom_range(0, sp), py0 + $urandom_range(0, sp),
                    $urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom_range(0, 255), $urandom_range(0, 255));
      end else begin
        tr = mk_tri($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom, $urandom);
      end
      rasterize(tr);
      // every third block of a dozen triangles runs back to back
      gap = ((k / 12) % 3 == 0) ? 0 : $urandom_range(0, 12);
      send_tri(tr, gap);
    end
    start <= 1'b0;

    // Drain outstanding rows, then let the pipeline settle
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    $display("Sent %0d triangles (%0d directed), checked %0d row results, %0d clipped boxes",
             n_triangles, n_directed, n_rows_seen, n_clipped);
    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
